/* sv/safs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types for the sprite animation frame sequencer.
// No dependencies; every other file of the block imports this package.
package safs_pkg;

    // Time and step limits
    localparam int TIME_BITS    = 20;
    localparam int ACC_W        = TIME_BITS + 1;
    localparam int MAX_ADVANCES = 16;
    localparam int ADV_W        = $clog2(MAX_ADVANCES + 1);

    // Field widths
    localparam int MAX_FRAMES = 256;
    localparam int FRAME_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int MODE_W     = 3;
    localparam int REQ_W      = 2;
    localparam int PIX_W      = 12;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;

    // Shared divider and multiplier sizes
    localparam int DIVD_W    = 13;
    localparam int DIVS_W    = 12;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
    localparam int MUL_W     = 16;
    localparam int PROD_W    = 2 * MUL_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd7;

    // Command codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PLAY   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESUME = 2'd3;

    // Play mode bit positions
    localparam int MODE_REV  = 0;
    localparam int MODE_PING = 1;
    localparam int MODE_LOOP = 2;

    // Register reset values
    localparam logic [MODE_W-1:0]    RST_PLAY_MODE    = 3'd4;
    localparam logic [COUNT_W-1:0]   RST_FRAME_COUNT  = 9'd1;
    localparam logic [TIME_BITS-1:0] RST_FRAME_PERIOD = 20'd16667;
    localparam logic [PIX_W-1:0]     RST_SHEET_WIDTH  = 12'd1;
    localparam logic [PIX_W-1:0]     RST_CELL_WIDTH   = 12'd1;
    localparam logic [PIX_W-1:0]     RST_CELL_HEIGHT  = 12'd1;

    // Effective configuration seen by the sequencer
    typedef struct packed {
        logic [MODE_W-1:0]    play_mode;
        logic [COUNT_W-1:0]   count;
        logic [TIME_BITS-1:0] period;
        logic [PIX_W-1:0]     sheet_w;
        logic [PIX_W-1:0]     cell_w;
        logic [PIX_W-1:0]     cell_h;
        logic [PIX_W-1:0]     org_x;
        logic [PIX_W-1:0]     org_y;
    } cfg_t;

    // Play mode write event
    typedef struct packed {
        logic load;
        logic reverse;
    } mode_evt_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quo;
        logic [DIVS_W-1:0] rem;
    } div_rsp_t;

endpackage

/* sv/safs_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on safs_pkg for field widths.
interface safs_cmd_if;
    import safs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [TIME_BITS-1:0] elapsed;

    modport source (output valid, req_type, elapsed, input ready);
    modport sink (input valid, req_type, elapsed, output ready);
endinterface

interface safs_res_if;
    import safs_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_index;
    logic               running;
    logic [OUT_W-1:0]   pixel_x;
    logic [OUT_W-1:0]   pixel_y;
    logic               lagging;

    modport source (output valid, frame_index, running, pixel_x, pixel_y, lagging,
                    input ready);
    modport sink (input valid, frame_index, running, pixel_x, pixel_y, lagging,
                  output ready);
endinterface

/* sv/safs_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle.
// Depends on safs_pkg for widths and the request/response structs.
module safs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  safs_pkg::div_req_t req,
    output safs_pkg::div_rsp_t rsp
);
    import safs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVS_W-1:0]    den_reg, den_next;
    logic [DIVS_W:0]      shifted;
    logic [DIVS_W:0]      diff;
    logic                 fits;

    // Trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    // Load on start, else shift in one quotient bit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVD_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            rem_next = fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* sv/safs_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file with clamping to effective values.
// Depends on safs_pkg for register indexes, reset values and cfg_t.
module safs_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [safs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [safs_pkg::CFG_W-1:0]           cfg_data,
    output safs_pkg::cfg_t                       cfg,
    output safs_pkg::mode_evt_t                  mode_evt
);
    import safs_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [TIME_BITS-1:0] period_reg;
    logic [PIX_W-1:0]     sheet_reg;
    logic [PIX_W-1:0]     cellw_reg;
    logic [PIX_W-1:0]     cellh_reg;
    logic [PIX_W-1:0]     orgx_reg;
    logic [PIX_W-1:0]     orgy_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RST_PLAY_MODE;
            count_reg  <= RST_FRAME_COUNT;
            period_reg <= RST_FRAME_PERIOD;
            sheet_reg  <= RST_SHEET_WIDTH;
            cellw_reg  <= RST_CELL_WIDTH;
            cellh_reg  <= RST_CELL_HEIGHT;
            orgx_reg   <= '0;
            orgy_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PLAY_MODE:    mode_reg   <= cfg_data[MODE_W-1:0];
                REG_FRAME_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                REG_FRAME_PERIOD: period_reg <= cfg_data[TIME_BITS-1:0];
                REG_SHEET_WIDTH:  sheet_reg  <= cfg_data[PIX_W-1:0];
                REG_CELL_WIDTH:   cellw_reg  <= cfg_data[PIX_W-1:0];
                REG_CELL_HEIGHT:  cellh_reg  <= cfg_data[PIX_W-1:0];
                REG_ORIGIN_X:     orgx_reg   <= cfg_data[PIX_W-1:0];
                REG_ORIGIN_Y:     orgy_reg   <= cfg_data[PIX_W-1:0];
            endcase
        end
    end

    // Clamp count to 1..MAX_FRAMES, period and cell width to at least 1
    always_comb
    begin
        cfg.play_mode = mode_reg;
        if (count_reg == '0)
            cfg.count = COUNT_W'(1);
        else if (count_reg > COUNT_W'(MAX_FRAMES))
            cfg.count = COUNT_W'(MAX_FRAMES);
        else
            cfg.count = count_reg;
        cfg.period  = (period_reg == '0) ? TIME_BITS'(1) : period_reg;
        cfg.sheet_w = sheet_reg;
        cfg.cell_w  = (cellw_reg == '0) ? PIX_W'(1) : cellw_reg;
        cfg.cell_h  = cellh_reg;
        cfg.org_x   = orgx_reg;
        cfg.org_y   = orgy_reg;
    end

    // A play mode write also restarts direction and frame
    assign mode_evt.load    = cfg_we && (cfg_index == REG_PLAY_MODE);
    assign mode_evt.reverse = cfg_data[MODE_REV];

endmodule

/* sv/safs_core.sv */
`timescale 1ns / 1ps
// Playback sequencer: command handling, period stepping loop and sheet position,
// using the shared divider (safs_div) and one shared multiplier. Depends on safs_pkg and safs_if.
module safs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  safs_pkg::cfg_t      cfg,
    input  safs_pkg::mode_evt_t mode_evt,
    output safs_pkg::div_req_t  div_req,
    input  safs_pkg::div_rsp_t  div_rsp,
    safs_cmd_if.sink            cmd,
    safs_res_if.source          res
);
    import safs_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_STEP  = 4'd1;
    localparam logic [3:0] ST_FMOD  = 4'd2;
    localparam logic [3:0] ST_PMUL  = 4'd3;
    localparam logic [3:0] ST_PCMP  = 4'd4;
    localparam logic [3:0] ST_PDIV1 = 4'd5;
    localparam logic [3:0] ST_PDIV2 = 4'd6;
    localparam logic [3:0] ST_PDIV3 = 4'd7;
    localparam logic [3:0] ST_PMULX = 4'd8;
    localparam logic [3:0] ST_PMULY = 4'd9;
    localparam logic [3:0] ST_PFIN  = 4'd10;
    localparam logic [3:0] ST_POUT  = 4'd11;

    function automatic logic [OUT_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        if (v < 0)
            return '0;
        else if (v > $signed(PROD_W'({OUT_W{1'b1}})))
            return '1;
        else
            return v[OUT_W-1:0];
    endfunction

    logic [3:0]                state_reg, state_next;
    logic                      playing_reg, playing_next;
    logic                      started_reg, started_next;
    logic                      back_reg, back_next;
    logic [FRAME_W-1:0]        frame_reg, frame_next;
    logic [ACC_W-1:0]          accum_reg, accum_next;
    logic [ADV_W-1:0]          adv_reg, adv_next;
    logic                      lag_reg, lag_next;
    logic signed [PROD_W-1:0]  mul_reg;
    logic signed [DIVD_W:0]    nw_reg, nw_next;
    logic signed [DIVD_W+1:0]  rq_reg, rq_next;
    logic signed [DIVS_W:0]    rr_reg, rr_next;
    logic [OUT_W-1:0]          px_reg, px_next;
    logic [OUT_W-1:0]          py_reg, py_next;
    logic                      ovalid_reg;
    logic [FRAME_W-1:0]        oframe_reg;
    logic                      orun_reg;
    logic [OUT_W-1:0]          opx_reg;
    logic [OUT_W-1:0]          opy_reg;
    logic                      olag_reg;

    logic                      cmd_xfer;
    logic                      out_load;
    logic [FRAME_W-1:0]        last_frame;
    logic [ACC_W:0]            acc_sum;
    logic [ACC_W-1:0]          acc_sat;
    logic                      per_ge;
    logic                      mode_r, mode_p, mode_l;
    logic signed [COUNT_W:0]   nx;
    logic                      at_top, at_bot;
    logic                      stop_s, tog_s, play_s, back_s;
    logic signed [COUNT_W:0]   n2;
    logic [COUNT_W-1:0]        n2u;
    logic [FRAME_W-1:0]        frame_s;
    logic                      need_div;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  x_lin, x_lim;
    logic signed [PIX_W:0]     span;
    logic [DIVD_W-1:0]         span_mag;
    logic signed [DIVD_W:0]    q1;
    logic [DIVD_W-1:0]         nw_mag;
    logic [DIVS_W-1:0]         cols;
    logic signed [DIVD_W:0]    rq;

    assign cmd_xfer   = cmd.valid && cmd.ready;
    assign out_load   = (state_reg == ST_POUT) && (!ovalid_reg || res.ready);
    assign last_frame = FRAME_W'(cfg.count - 1'b1);

    // Accumulate elapsed time, saturating
    assign acc_sum = {1'b0, accum_reg} + {2'b0, cmd.elapsed};
    assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    assign per_ge  = accum_reg >= {1'b0, cfg.period};

    // End-of-range rules for one frame step
    assign mode_r = cfg.play_mode[MODE_REV];
    assign mode_p = cfg.play_mode[MODE_PING];
    assign mode_l = cfg.play_mode[MODE_LOOP];
    assign nx     = $signed({2'b0, frame_reg}) + (back_reg ? -(COUNT_W+1)'(1) : (COUNT_W+1)'(1));
    assign at_top = nx == $signed({1'b0, cfg.count});
    assign at_bot = nx[COUNT_W];
    assign stop_s = (at_top && !mode_l && (mode_r == mode_p))
                 || (at_bot && !mode_l && (mode_r != mode_p));
    assign tog_s  = (at_top && mode_p && (mode_l || !mode_r))
                 || (at_bot && mode_p && (mode_l || mode_r));
    assign play_s = playing_reg && !stop_s;
    assign back_s = back_reg ^ tog_s;

    // Next frame reduced into 0..count-1; far out of range goes to the divider
    assign n2  = $signed({2'b0, frame_reg}) + (back_s ? -(COUNT_W+1)'(1) : (COUNT_W+1)'(1));
    assign n2u = n2[COUNT_W-1:0];
    always_comb
    begin
        need_div = 1'b0;
        frame_s  = frame_reg;
        if (n2[COUNT_W])
            frame_s = last_frame;
        else if (n2u < cfg.count)
            frame_s = n2u[FRAME_W-1:0];
        else if ({1'b0, n2u} < {cfg.count, 1'b0})
            frame_s = FRAME_W'(n2u - cfg.count);
        else
            need_div = 1'b1;
    end

    // Sheet position terms
    assign x_lin    = $signed(PROD_W'(cfg.org_x)) + mul_reg;
    assign x_lim    = $signed(PROD_W'(cfg.sheet_w)) - $signed(PROD_W'(cfg.cell_w));
    assign span     = $signed({1'b0, cfg.sheet_w}) - $signed({1'b0, cfg.org_x});
    assign span_mag = DIVD_W'(span[PIX_W] ? -span : span);
    assign q1       = span[PIX_W] ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
    assign nw_mag   = nw_reg[DIVD_W] ? DIVD_W'(-nw_reg) : nw_reg[DIVD_W-1:0];
    assign cols     = (div_rsp.quo[DIVS_W-1:0] == '0) ? DIVS_W'(1) : div_rsp.quo[DIVS_W-1:0];
    assign rq       = nw_reg[DIVD_W] ? -$signed({1'b0, div_rsp.quo})
                                     : $signed({1'b0, div_rsp.quo});

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_PMULX:
            begin
                mul_a = MUL_W'(rr_reg);
                mul_b = $signed(MUL_W'(cfg.cell_w));
            end
            ST_PMULY:
            begin
                mul_a = MUL_W'(rq_reg);
                mul_b = $signed(MUL_W'(cfg.cell_h));
            end
            default:
            begin
                mul_a = $signed(MUL_W'(frame_reg));
                mul_b = $signed(MUL_W'(cfg.cell_w));
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        playing_next = playing_reg;
        started_next = started_reg;
        back_next    = back_reg;
        frame_next   = frame_reg;
        accum_next   = accum_reg;
        adv_next     = adv_reg;
        lag_next     = lag_reg;
        nw_next      = nw_reg;
        rq_next      = rq_reg;
        rr_next      = rr_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        div_req      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    lag_next   = 1'b0;
                    adv_next   = '0;
                    state_next = ST_PMUL;
                    unique case (cmd.req_type)
                        REQ_PLAY:
                        begin
                            playing_next = 1'b1;
                            started_next = 1'b1;
                            back_next    = mode_r;
                            frame_next   = mode_r ? last_frame : '0;
                        end
                        REQ_STOP:   playing_next = 1'b0;
                        REQ_RESUME: playing_next = 1'b1;
                        REQ_TICK:
                        begin
                            if (playing_reg)
                            begin
                                state_next = ST_STEP;
                                if (started_reg)
                                begin
                                    accum_next   = '0;
                                    started_next = 1'b0;
                                end
                                else
                                    accum_next = acc_sat;
                            end
                        end
                    endcase
                end
                // Play mode write: restart direction and frame
                if (mode_evt.load)
                begin
                    back_next  = mode_evt.reverse;
                    frame_next = mode_evt.reverse ? last_frame : '0;
                end
            end

            ST_STEP:
            begin
                if ((adv_reg != ADV_W'(MAX_ADVANCES)) && per_ge)
                begin
                    accum_next   = accum_reg - {1'b0, cfg.period};
                    adv_next     = adv_reg + 1'b1;
                    playing_next = play_s;
                    back_next    = back_s;
                    if (play_s && need_div)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVD_W'(n2u);
                        div_req.divisor  = DIVS_W'(cfg.count);
                        state_next       = ST_FMOD;
                    end
                    else if (play_s)
                        frame_next = frame_s;
                end
                else
                begin
                    lag_next   = per_ge;
                    state_next = ST_PMUL;
                end
            end

            ST_FMOD:
            begin
                if (div_rsp.done)
                begin
                    frame_next = div_rsp.rem[FRAME_W-1:0];
                    state_next = ST_STEP;
                end
            end

            ST_PMUL: state_next = ST_PCMP;

            ST_PCMP:
            begin
                if (x_lin > x_lim)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = span_mag;
                    div_req.divisor  = cfg.cell_w;
                    state_next       = ST_PDIV1;
                end
                else
                begin
                    px_next    = x_lin[OUT_W-1:0];
                    py_next    = OUT_W'(cfg.org_y);
                    state_next = ST_POUT;
                end
            end

            // Frame shifted by the columns between the origin and the right edge of the sheet
            ST_PDIV1:
            begin
                if (div_rsp.done)
                begin
                    nw_next          = $signed((DIVD_W+1)'(frame_reg)) - q1;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVD_W'(cfg.sheet_w);
                    div_req.divisor  = cfg.cell_w;
                    state_next       = ST_PDIV2;
                end
            end

            // Column count, then row and column of the shifted frame
            ST_PDIV2:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = nw_mag;
                    div_req.divisor  = cols;
                    state_next       = ST_PDIV3;
                end
            end

            ST_PDIV3:
            begin
                if (div_rsp.done)
                begin
                    rq_next    = (DIVD_W+2)'(rq) + (DIVD_W+2)'(1);
                    rr_next    = nw_reg[DIVD_W] ? -$signed({1'b0, div_rsp.rem})
                                                : $signed({1'b0, div_rsp.rem});
                    state_next = ST_PMULX;
                end
            end

            ST_PMULX: state_next = ST_PMULY;

            ST_PMULY:
            begin
                px_next    = sat16(mul_reg);
                state_next = ST_PFIN;
            end

            ST_PFIN:
            begin
                py_next    = sat16($signed(PROD_W'(cfg.org_y)) + mul_reg);
                state_next = ST_POUT;
            end

            ST_POUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control and playback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            playing_reg <= 1'b0;
            started_reg <= 1'b1;
            back_reg    <= 1'b0;
            frame_reg   <= '0;
            accum_reg   <= '0;
            adv_reg     <= '0;
            lag_reg     <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            playing_reg <= playing_next;
            started_reg <= started_next;
            back_reg    <= back_next;
            frame_reg   <= frame_next;
            accum_reg   <= accum_next;
            adv_reg     <= adv_next;
            lag_reg     <= lag_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (res.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        nw_reg  <= nw_next;
        rq_reg  <= rq_next;
        rr_reg  <= rr_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        if (out_load)
        begin
            oframe_reg <= frame_reg;
            orun_reg   <= playing_reg;
            opx_reg    <= px_reg;
            opy_reg    <= py_reg;
            olag_reg   <= lag_reg;
        end
    end

    assign cmd.ready       = state_reg == ST_IDLE;
    assign res.valid       = ovalid_reg;
    assign res.frame_index = oframe_reg;
    assign res.running     = orun_reg;
    assign res.pixel_x     = opx_reg;
    assign res.pixel_y     = opy_reg;
    assign res.lagging     = olag_reg;

`ifndef SYNTHESIS
    // Divider results arrive only while the sequencer waits for them
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_FMOD || state_reg == ST_PDIV1
                          || state_reg == ST_PDIV2 || state_reg == ST_PDIV3))
        else $error("divider done outside a wait state");

    // The step loop never runs past its limit
    a_adv_limit: assert property (@(posedge clk) disable iff (!rst_n)
        adv_reg <= ADV_W'(MAX_ADVANCES))
        else $error("step count beyond limit");

    // Leaving the step loop without lag means less than one period is left
    a_no_lag_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PMUL && $past(state_reg) == ST_STEP && !lag_reg)
        |-> accum_reg < {1'b0, cfg.period})
        else $error("whole period left without lag flag");

    // A result only appears from the output load state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_POUT)
        else $error("result valid raised outside output state");
`endif

endmodule

/* sv/sprite_animation_frame_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the sprite animation frame sequencer.
// Depends on safs_pkg, safs_if, safs_cfg, safs_div and safs_core.

// Each command (tick, play, stop, resume) returns exactly one result with the
// current frame, its pixel position on the sheet and the running/lagging flags.
// One command is worked on at a time; the command channel is ready only when
// the sequencer is idle, while a finished result may still wait in the output
// register. A tick steps the frame once per frame period consumed, at most 16
// times; play, stop, resume and ticks while stopped step nothing. When the
// current frame sits past the first row of the sheet, the position takes three
// passes through the shared divider. A step that must reduce a frame lying far
// beyond a newly shortened frame count takes one more pass through it.
// Register writes are taken at any time but must only be issued while idle.
module sprite_animation_frame_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    safs_cmd_if.sink                       cmd,
    safs_res_if.source                     res,
    input  logic                           cfg_we,
    input  logic [safs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [safs_pkg::CFG_W-1:0]     cfg_data
);
    import safs_pkg::*;

    cfg_t      cfg;
    mode_evt_t mode_evt;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // Configuration registers
    safs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .mode_evt  (mode_evt)
    );

    // Shared divider
    safs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Playback sequencer
    safs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .mode_evt (mode_evt),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .cmd      (cmd),
        .res      (res)
    );

endmodule

/* test/sprite_animation_frame_sequencer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sprite animation frame sequencer: a directed table,
// then randomized phases, each result checked against a behavioral predictor or a table entry.
// Depends on safs_pkg, safs_if and the sprite_animation_frame_sequencer top level.
module sprite_animation_frame_sequencer_test;
    import safs_pkg::*;

    localparam int     HALF_PERIOD    = 4;
    localparam int     RESET_CYCLES   = 4;
    localparam int     IDLE_PCT       = 21;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     END_CYCLES     = 100;
    localparam int     PHASES         = 12;
    localparam int     PHASE_ITEMS    = 90;
    localparam longint TIMEOUT_NS     = 6_000_000;
    localparam longint ACC_MAX        = (longint'(1) << ACC_W) - 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic               running;
        logic [OUT_W-1:0]   pixel_x;
        logic [OUT_W-1:0]   pixel_y;
        logic               lagging;
    } frame_report_t;

    typedef enum logic [1:0] {ROW_REG, ROW_CMD, ROW_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
        logic [REQ_W-1:0]     req;
        logic [TIME_BITS-1:0] el;
        frame_report_t        want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    safs_cmd_if cmd_ch ();
    safs_res_if res_ch ();

    sprite_animation_frame_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    frame_report_t expected_reports[$];
    stim_row_t     directed_rows[$];
    int            mismatches    = 0;
    int            hold_requests = 0;
    bit            gaps_on       = 1'b1;

    // Predictor copy of the registers
    logic [MODE_W-1:0]    cfg_mode;
    logic [COUNT_W-1:0]   cfg_count;
    logic [TIME_BITS-1:0] cfg_period;
    logic [PIX_W-1:0]     cfg_sheet_w;
    logic [PIX_W-1:0]     cfg_cell_w;
    logic [PIX_W-1:0]     cfg_cell_h;
    logic [PIX_W-1:0]     cfg_org_x;
    logic [PIX_W-1:0]     cfg_org_y;

    // Predictor copy of the playback state
    bit                 anim_playing;
    bit                 anim_fresh;
    bit                 anim_backward;
    logic [FRAME_W-1:0] anim_frame;
    logic [ACC_W-1:0]   anim_accum;

    function automatic void reset_predictor();
        cfg_mode      = RST_PLAY_MODE;
        cfg_count     = RST_FRAME_COUNT;
        cfg_period    = RST_FRAME_PERIOD;
        cfg_sheet_w   = RST_SHEET_WIDTH;
        cfg_cell_w    = RST_CELL_WIDTH;
        cfg_cell_h    = RST_CELL_HEIGHT;
        cfg_org_x     = '0;
        cfg_org_y     = '0;
        anim_playing  = 1'b0;
        anim_fresh    = 1'b1;
        anim_backward = 1'b0;
        anim_frame    = '0;
        anim_accum    = '0;
    endfunction

    // Zero count counts as one frame; counts above the table size saturate
    function automatic longint frames_in_use();
        longint c;
        c = cfg_count;
        if (c == 0) c = 1;
        if (c > MAX_FRAMES) c = MAX_FRAMES;
        return c;
    endfunction

    function automatic void land_on_frame(input longint n);
        longint c;
        c = frames_in_use();
        n = n % c;
        if (n < 0) n += c;
        anim_frame = FRAME_W'(n);
    endfunction

    // Point the direction from the reverse bit and jump to the matching end
    function automatic void rewind_to_start();
        if (cfg_mode[MODE_REV]) begin
            anim_backward = 1'b1;
            land_on_frame(frames_in_use() - 1);
        end
        else begin
            anim_backward = 1'b0;
            land_on_frame(0);
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] val);
        case (idx)
            REG_PLAY_MODE:
            begin
                cfg_mode = val[MODE_W-1:0];
                rewind_to_start();
            end
            REG_FRAME_COUNT:  cfg_count   = val[COUNT_W-1:0];
            REG_FRAME_PERIOD: cfg_period  = val[TIME_BITS-1:0];
            REG_SHEET_WIDTH:  cfg_sheet_w = val[PIX_W-1:0];
            REG_CELL_WIDTH:   cfg_cell_w  = val[PIX_W-1:0];
            REG_CELL_HEIGHT:  cfg_cell_h  = val[PIX_W-1:0];
            REG_ORIGIN_X:     cfg_org_x   = val[PIX_W-1:0];
            REG_ORIGIN_Y:     cfg_org_y   = val[PIX_W-1:0];
            default: ;
        endcase
    endfunction

    // One frame step; the end rules run even after playback has stopped in this tick
    function automatic void step_frame();
        longint c;
        longint nx;
        bit     rev;
        bit     ping;
        bit     loop_on;
        c       = frames_in_use();
        rev     = cfg_mode[MODE_REV];
        ping    = cfg_mode[MODE_PING];
        loop_on = cfg_mode[MODE_LOOP];
        nx      = longint'(anim_frame) + (anim_backward ? -1 : 1);
        if (nx == c) begin
            if (!loop_on && (ping == rev)) anim_playing = 1'b0;
            else if (ping && (loop_on || !rev)) anim_backward = !anim_backward;
        end
        else if (nx < 0) begin
            if (!loop_on && (ping != rev)) anim_playing = 1'b0;
            else if (ping && (loop_on || rev)) anim_backward = !anim_backward;
        end
        if (anim_playing)
            land_on_frame(longint'(anim_frame) + (anim_backward ? -1 : 1));
    endfunction

    function automatic logic [OUT_W-1:0] clamp16(input longint v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return OUT_W'(v);
    endfunction

    // Apply one command to the predictor and build the report it causes
    function automatic frame_report_t advance_sequencer(input logic [REQ_W-1:0] req,
                                                        input logic [TIME_BITS-1:0] el);
        frame_report_t rep;
        longint        per;
        longint        acc;
        longint        n;
        longint        w;
        longint        sw;
        longint        tx;
        longint        x;
        longint        y;
        longint        cols;
        bit            lag;
        lag = 1'b0;
        case (req)
            REQ_PLAY:
            begin
                anim_playing = 1'b1;
                anim_fresh   = 1'b1;
                rewind_to_start();
            end
            REQ_STOP:   anim_playing = 1'b0;
            REQ_RESUME: anim_playing = 1'b1;
            default:
            begin
                if (anim_playing) begin
                    per = cfg_period;
                    if (per == 0) per = 1;
                    if (anim_fresh) begin
                        acc        = 0;
                        anim_fresh = 1'b0;
                    end
                    else begin
                        acc = longint'(anim_accum) + longint'(el);
                        if (acc > ACC_MAX) acc = ACC_MAX;
                    end
                    for (int k = 0; k < MAX_ADVANCES && acc >= per; k++) begin
                        acc -= per;
                        step_frame();
                    end
                    lag        = (acc >= per);
                    anim_accum = ACC_W'(acc);
                end
            end
        endcase

        // Position on the sheet, wrapping to following rows past the right edge
        n  = anim_frame;
        w  = (cfg_cell_w == 0) ? 1 : cfg_cell_w;
        sw = cfg_sheet_w;
        tx = cfg_org_x;
        x  = tx + n * w;
        y  = cfg_org_y;
        if (x > sw - w) begin
            cols = sw / w;
            if (cols < 1) cols = 1;
            n -= (sw - tx) / w;
            x = w * (n % cols);
            y += longint'(cfg_cell_h) * (1 + n / cols);
        end
        rep.frame_index = anim_frame;
        rep.running     = anim_playing;
        rep.pixel_x     = clamp16(x);
        rep.pixel_y     = clamp16(y);
        rep.lagging     = lag;
        return rep;
    endfunction

    function automatic frame_report_t make_report(input logic [FRAME_W-1:0] f, input bit r,
                                                  input logic [OUT_W-1:0] x,
                                                  input logic [OUT_W-1:0] y, input bit l);
        return '{f, r, x, y, l};
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        directed_rows.push_back('{ROW_REG, idx, val, REQ_TICK, '0, '0});
    endfunction

    function automatic void add_cmd(input logic [REQ_W-1:0] req,
                                    input logic [TIME_BITS-1:0] el);
        directed_rows.push_back('{ROW_CMD, REG_PLAY_MODE, '0, req, el, '0});
    endfunction

    function automatic void add_typed(input logic [REQ_W-1:0] req,
                                      input logic [TIME_BITS-1:0] el,
                                      input frame_report_t want);
        directed_rows.push_back('{ROW_TYPED, REG_PLAY_MODE, '0, req, el, want});
    endfunction

    function automatic void build_directed_rows();
        // Reset settings: stopped at frame zero, one frame on a one pixel sheet
        add_typed(REQ_TICK, TIME_MAX, make_report(0, 0, 0, 0, 0));
        add_typed(REQ_STOP, '0, make_report(0, 0, 0, 0, 0));
        add_typed(REQ_RESUME, '0, make_report(0, 1, 0, 0, 0));
        // First tick after reset only clears the accumulator
        add_typed(REQ_TICK, '0, make_report(0, 1, 0, 0, 0));
        add_cmd(REQ_TICK, TIME_MAX);

        // Reverse without loop, zero period, widest cells far off the sheet
        add_reg(REG_FRAME_COUNT, 5);
        add_reg(REG_FRAME_PERIOD, 0);
        add_reg(REG_SHEET_WIDTH, 4095);
        add_reg(REG_CELL_WIDTH, 4095);
        add_reg(REG_CELL_HEIGHT, 4095);
        add_reg(REG_ORIGIN_X, 4095);
        add_reg(REG_ORIGIN_Y, 4095);
        add_reg(REG_PLAY_MODE, 1);
        add_cmd(REQ_PLAY, TIME_MAX);
        add_cmd(REQ_TICK, 20'd7);
        add_cmd(REQ_TICK, 20'd3);
        add_cmd(REQ_TICK, TIME_MAX);
        add_cmd(REQ_RESUME, '0);
        add_cmd(REQ_TICK, 20'd1);

        // Zero count, zero cell width, no whole column, accumulator saturation
        add_reg(REG_CELL_WIDTH, 0);
        add_reg(REG_SHEET_WIDTH, 0);
        add_reg(REG_ORIGIN_X, 0);
        add_reg(REG_ORIGIN_Y, 0);
        add_reg(REG_CELL_HEIGHT, 1);
        add_reg(REG_FRAME_PERIOD, 1);
        add_reg(REG_FRAME_COUNT, 0);
        add_reg(REG_PLAY_MODE, 6);
        add_cmd(REQ_PLAY, '0);
        add_cmd(REQ_TICK, TIME_MAX);
        add_cmd(REQ_TICK, TIME_MAX);
        add_cmd(REQ_TICK, TIME_MAX);
        add_cmd(REQ_STOP, '0);
        add_cmd(REQ_TICK, TIME_MAX);

        // Saturated count, reverse ping-pong loop, multi-row sheet
        add_reg(REG_FRAME_COUNT, 511);
        add_reg(REG_PLAY_MODE, 7);
        add_reg(REG_SHEET_WIDTH, 64);
        add_reg(REG_CELL_WIDTH, 8);
        add_reg(REG_CELL_HEIGHT, 8);
        add_reg(REG_ORIGIN_X, 16);
        add_reg(REG_ORIGIN_Y, 100);
        add_reg(REG_FRAME_PERIOD, 100);
        add_cmd(REQ_RESUME, '0);
        add_cmd(REQ_TICK, 20'd1000);
        add_cmd(REQ_TICK, 20'd2000);

        // Shrink the count under the current frame, longest period
        add_reg(REG_FRAME_COUNT, 3);
        add_reg(REG_FRAME_PERIOD, 1048575);
        add_cmd(REQ_TICK, TIME_MAX);
        add_cmd(REQ_PLAY, '0);
        add_cmd(REQ_TICK, 20'd5);
        add_cmd(REQ_TICK, TIME_MAX);
    endfunction

    // Register value biased toward the extremes
    function automatic logic [CFG_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 6) return CFG_W'($urandom_range(1, 16));
        return CFG_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_period();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return CFG_W'(RST_FRAME_PERIOD);
        if (r < 7) return CFG_W'($urandom_range(1, 64));
        return CFG_W'($urandom_range(1, 5000));
    endfunction

    // Elapsed time: mostly a few periods plus a fraction, some extremes and noise
    function automatic logic [TIME_BITS-1:0] pick_elapsed();
        int unsigned r;
        longint      per;
        longint      el;
        r   = $urandom_range(9);
        per = (cfg_period == 0) ? 1 : cfg_period;
        if (r == 0) return '0;
        if (r == 1) return TIME_MAX;
        if (r < 4) return TIME_BITS'($urandom);
        el = per * $urandom_range(0, 3) + $urandom_range(0, int'(per - 1));
        if (el > longint'(TIME_MAX)) el = TIME_MAX;
        return TIME_BITS'(el);
    endfunction

    // Offer one command, then predict its report once the transfer happens
    task automatic send_command(input logic [REQ_W-1:0] req, input logic [TIME_BITS-1:0] el,
                                input bit typed, input frame_report_t want);
        frame_report_t predicted;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.req_type <= req;
        cmd_ch.elapsed  <= el;
        do @(posedge clk); while (!cmd_ch.ready);
        predicted = advance_sequencer(req, el);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every report has come and the block is idle
    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_register(idx, val);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Load all registers: style 0 all zero, 1 all ones, otherwise random
    task automatic load_registers(input int style);
        logic [CFG_W-1:0] vals [8];
        bit               mode_first;
        for (int i = 0; i < 8; i++)
            vals[i] = (style == 0) ? '0 : (style == 1) ? '1 : pick_value();
        if (style > 1) vals[REG_FRAME_PERIOD] = pick_period();
        mode_first = $urandom_range(1);
        if (mode_first) write_reg(REG_PLAY_MODE, vals[REG_PLAY_MODE]);
        for (int i = 1; i < 8; i++) write_reg(CFG_IDX_W'(i), vals[i]);
        if (!mode_first) write_reg(REG_PLAY_MODE, vals[REG_PLAY_MODE]);
        end_writes();
    endtask

    // Result receiver: random stalls, plus long hold-offs on request
    initial begin
        int unsigned held;
        int          holds_served;
        held         = 0;
        holds_served = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != holds_served) begin
                held         = HOLD_CYCLES;
                holds_served = hold_requests;
            end
            if (held > 0) begin
                held--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each result transfer with the oldest expected report
    always @(posedge clk) begin
        frame_report_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_reports.size() == 0) begin
                $error("result transfer with no report expected");
                mismatches++;
            end
            else begin
                want = expected_reports.pop_front();
                if (res_ch.frame_index !== want.frame_index) begin
                    $error("frame_index: expected %0d, actual %0d",
                           want.frame_index, res_ch.frame_index);
                    mismatches++;
                end
                if (res_ch.running !== want.running) begin
                    $error("running: expected %0d, actual %0d", want.running, res_ch.running);
                    mismatches++;
                end
                if (res_ch.pixel_x !== want.pixel_x) begin
                    $error("pixel_x: expected %0d, actual %0d", want.pixel_x, res_ch.pixel_x);
                    mismatches++;
                end
                if (res_ch.pixel_y !== want.pixel_y) begin
                    $error("pixel_y: expected %0d, actual %0d", want.pixel_y, res_ch.pixel_y);
                    mismatches++;
                end
                if (res_ch.lagging !== want.lagging) begin
                    $error("lagging: expected %0d, actual %0d", want.lagging, res_ch.lagging);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        bit               writing;
        int unsigned      r;
        logic [REQ_W-1:0] req;
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.req_type = REQ_TICK;
        cmd_ch.elapsed  = '0;
        cfg_we          = 1'b0;
        cfg_index       = REG_PLAY_MODE;
        cfg_data        = '0;
        writing         = 1'b0;
        reset_predictor();
        build_directed_rows();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; register rows go in only once the block is idle
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                if (!writing) drain_results();
                writing = 1'b1;
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end
            else begin
                if (writing) end_writes();
                writing = 1'b0;
                send_command(directed_rows[i].req, directed_rows[i].el,
                             directed_rows[i].kind == ROW_TYPED, directed_rows[i].want);
            end
        end

        // Random phases: fresh settings, play, then mostly ticks
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            load_registers(phase < 2 ? phase : 2);
            gaps_on = (phase != 6);
            send_command(REQ_PLAY, TIME_BITS'($urandom), 1'b0, '0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 3 && i == 20) hold_requests++;
                if (phase == 5 && i == 40) drain_results();
                r = $urandom_range(99);
                if (r < 5) req = REQ_PLAY;
                else if (r < 9) req = REQ_STOP;
                else if (r < 14) req = REQ_RESUME;
                else req = REQ_TICK;
                send_command(req, pick_elapsed(), 1'b0, '0);
            end
        end
        gaps_on = 1'b1;

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
